@@ hdl/ile_pkg.sv @@
`timescale 1ns / 1ps

package ile_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned LEN_W  = 7;

  typedef enum logic [2:0] {
    KIND_READ     = 3'd0,
    KIND_INS_HEAD = 3'd1,
    KIND_INS_TAIL = 3'd2,
    KIND_INS_AT   = 3'd3,
    KIND_DELETE   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what every cell of the row does
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

endpackage

@@ hdl/ile_in_if.sv @@
`timescale 1ns / 1ps

interface ile_in_if
  import ile_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [2:0]               kind;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output kind, output position, output item_value,
                  input ready);
  modport sink   (input valid, input kind, input position, input item_value,
                  output ready);
endinterface

@@ hdl/ile_out_if.sv @@
`timescale 1ns / 1ps

interface ile_out_if
  import ile_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [1:0]               status;
  logic [LEN_W-1:0]         length;

  modport source (output valid, output read_value, output status, output length,
                  input ready);
  modport sink   (input valid, input read_value, input status, input length,
                  output ready);
endinterface

@@ hdl/ile_cell.sv @@
`timescale 1ns / 1ps

module ile_cell
  import ile_pkg::*;
#(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned IDX   = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [IDX_W-1:0]         pos,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tap
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     at_pos;
  logic                     past_pos;

  assign at_pos   = (pos == MY_IDX);
  assign past_pos = (MY_IDX > pos);

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      CELL_INSERT: begin
        if (at_pos) begin
          data_nxt = ctl.value;
        end else if (past_pos) begin
          data_nxt = left_data;
        end
      end
      CELL_DELETE: begin
        if (at_pos || past_pos) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  // gated for the one-hot read select in the top level
  assign tap  = at_pos ? data_r : '0;

endmodule

@@ hdl/indexed_list_engine.sv @@
// indexed_list_engine: ordered list of signed 32-bit values in a row of cells
// an accepted item's result is registered straight into the output register
// throughput: one item per cycle unless the output stalls; an insert or delete
//   shifts the row and a read selects one cell by a one-hot and-or over the row
// reset: clears the element count and the output valid; cell contents stay unknown
`timescale 1ns / 1ps

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ile_in_if.sink    in_ch,
  ile_out_if.source out_ch
);

  // index into the row, count that can also hold CAPACITY itself
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // common width for comparing the position field against the count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // element count and output register
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] rd_r;
  logic signed [DATA_W-1:0] rd_nxt;
  status_t                  st_r;
  status_t                  st_nxt;
  logic [LEN_W-1:0]         len_r;

  logic                     accept;
  logic [CMP_W-1:0]         pos_x;
  logic [CMP_W-1:0]         cnt_x;
  logic                     full;
  logic [IDX_W-1:0]         sel_pos;
  cell_op_t                 op;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] rd_any;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  logic signed [DATA_W-1:0] taps   [CAPACITY];

  // the output register frees itself in the cycle it is taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign pos_x = CMP_W'(in_ch.position);
  assign cnt_x = CMP_W'(cnt_r);
  assign full  = (cnt_r == CAP_CNT);

  // row position the item works on; also steers the read select
  always_comb begin
    sel_pos = pos_x[IDX_W-1:0];
    unique case (in_ch.kind)
      KIND_INS_HEAD: sel_pos = '0;
      // when not full the count is below CAPACITY and fits the index
      KIND_INS_TAIL: sel_pos = cnt_r[IDX_W-1:0];
      default:       sel_pos = pos_x[IDX_W-1:0];
    endcase
  end

  // decode the item; the row only moves when an insert or delete is legal
  always_comb begin
    op      = CELL_HOLD;
    st_nxt  = ST_DONE;
    rd_nxt  = MISS_VALUE;
    unique case (in_ch.kind)
      KIND_READ: begin
        if (pos_x < cnt_x) begin
          rd_nxt = rd_any;
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      KIND_INS_HEAD: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          op = CELL_INSERT;
        end
      end
      KIND_INS_TAIL: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          op = CELL_INSERT;
        end
      end
      KIND_INS_AT: begin
        if (pos_x > cnt_x) begin
          st_nxt = ST_RANGE;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          op = CELL_INSERT;
        end
      end
      KIND_DELETE: begin
        if (pos_x >= cnt_x) begin
          st_nxt = ST_RANGE;
        end else begin
          op = CELL_DELETE;
        end
      end
      default: st_nxt = ST_RANGE;
    endcase
  end

  always_comb begin
    unique case (op)
      CELL_INSERT: cnt_nxt = cnt_r + CNT_W'(1);
      CELL_DELETE: cnt_nxt = cnt_r - CNT_W'(1);
      default:     cnt_nxt = cnt_r;
    endcase
  end

  assign ctl.op    = accept ? op : CELL_HOLD;
  assign ctl.value = in_ch.item_value;

  // the row of cells: each one takes from its left neighbor on an insert
  // and from its right neighbor on a delete
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // the last cell falls outside the count after a delete
      assign right_d = cell_q[i];
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end

    ile_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (sel_pos),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i]),
      .tap        (taps[i])
    );
  end

  // one-hot read select: only the cell at the position drives its tap
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r  <= rd_nxt;
      st_r  <= st_nxt;
      len_r <= LEN_W'(cnt_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = rd_r;
  assign out_ch.status     = st_r;
  assign out_ch.length     = len_r;

  // count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("element count above capacity");

  // a refused item leaves the count alone
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && st_nxt != ST_DONE) |=> (cnt_r == $past(cnt_r)))
    else $error("count changed on a refused item");

  // a full status is only reported with the store at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r == ST_FULL) |-> (len_r == LEN_W'(CAPACITY)))
    else $error("full status with store below capacity");

  // anything but a successful operation reads as the miss value
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r != ST_DONE) |-> (rd_r == MISS_VALUE))
    else $error("read value not the miss value on a refused item");

endmodule
